>>> src/qhe_pkg.sv
// Shared types, constants and coefficient table for the quintic Hermite evaluator.
// No dependencies; every other file refers to it by scoped names.
package qhe_pkg;

  localparam int AXES_DEF       = 3;
  localparam int COORD_BITS_DEF = 16;
  localparam int NAX            = 3;   // output fields always carry three axes
  localparam int TIME_W         = 16;
  localparam int U_W            = 17;  // Q0.16 plus one integer bit for 1.0
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int RES_W          = 32;
  localparam int WGT_W          = 28;  // Horner accumulator, Q16 signed
  localparam int NLANE          = 6;   // three bases at u, three at 1-u
  localparam int NTERM          = 6;
  localparam int HORNER         = 5;
  localparam int FIFO_DEPTH     = 4;
  localparam int QONE           = 65536;

  localparam logic [1:0] MODE_POS = 2'd0;
  localparam logic [1:0] MODE_VEL = 2'd1;
  localparam logic [1:0] MODE_ACC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_T_START    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_END      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_POS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_VEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_ACC  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_ACC    = 3'd7;

  // [mode][basis h05,h15,h25][power 0..5], Q16
  localparam int COEF_TAB [3][3][6] = '{
    '{
      '{QONE, 0, 0, -10*QONE, 15*QONE, -6*QONE},
      '{0, QONE, 0, -6*QONE, 8*QONE, -3*QONE},
      '{0, 0, QONE/2, -3*QONE/2, 3*QONE/2, -QONE/2}
    },
    '{
      '{0, 0, -30*QONE, 60*QONE, -30*QONE, 0},
      '{QONE, 0, -18*QONE, 32*QONE, -15*QONE, 0},
      '{0, QONE, -9*QONE/2, 6*QONE, -5*QONE/2, 0}
    },
    '{
      '{0, -60*QONE, 180*QONE, -120*QONE, 0, 0},
      '{0, -36*QONE, 96*QONE, -60*QONE, 0, 0},
      '{QONE, -9*QONE, 18*QONE, -10*QONE, 0, 0}
    }
  };

  typedef struct packed {
    logic [1:0]     mode;
    logic           flag;
    logic [U_W-1:0] u;
  } item_t;

  // unused mode code reads the position row; its outputs are zeroed later
  function automatic logic signed [WGT_W-1:0] coef(input logic [1:0] m, input int b,
                                                   input int k);
    return WGT_W'(COEF_TAB[(m > MODE_ACC) ? 0 : int'(m)][b][k]);
  endfunction

endpackage

>>> src/quintic_hermite_eval.sv
// Quintic Hermite segment evaluator, up to three axes.
// Pipeline: 27 register stages, the first loaded at the transfer edge (1 classify, 17 divider
// stages, queue, 6 Horner stages, weighting, output).
// Throughput: one item per cycle while the output is not stalled, set by the fully pipelined
// divider and Horner lanes.
// Reset: synchronous active-low rst_n empties every stage and the queue and
// restores the segment registers (t_end all ones, the rest zero).
module quintic_hermite_eval #(
  parameter int AXES       = qhe_pkg::AXES_DEF,
  parameter int COORD_BITS = qhe_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] sample_time
  input  logic [1:0]                        in_tuser,   // [1:0] mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [103:0]                      out_tdata,  // out_x, out_y, out_z, time_out_of_range
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qhe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qhe_pkg::CFG_W-1:0]         cfg_data
);

  localparam int TW = qhe_pkg::TIME_W;
  localparam int CFW = qhe_pkg::CFG_W;
  localparam int RW = qhe_pkg::RES_W;

  logic [TW-1:0]  t_start_r, t_end_r;
  logic [CFW-1:0] p1_r, p2_r, v1_r, v2_r, a1_r, a2_r;

  logic           item_valid, item_ready;
  qhe_pkg::item_t item;
  logic           q_valid, q_ready;
  qhe_pkg::item_t q_item;
  logic [RW-1:0]  res_x, res_y, res_z;
  logic           res_flag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_start_r <= '0;
      t_end_r   <= '1;
      p1_r      <= '0;
      p2_r      <= '0;
      v1_r      <= '0;
      v2_r      <= '0;
      a1_r      <= '0;
      a2_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qhe_pkg::REG_T_START:   t_start_r <= cfg_data[TW-1:0];
        qhe_pkg::REG_T_END:     t_end_r   <= cfg_data[TW-1:0];
        qhe_pkg::REG_START_POS: p1_r      <= cfg_data;
        qhe_pkg::REG_END_POS:   p2_r      <= cfg_data;
        qhe_pkg::REG_START_VEL: v1_r      <= cfg_data;
        qhe_pkg::REG_END_VEL:   v2_r      <= cfg_data;
        qhe_pkg::REG_START_ACC: a1_r      <= cfg_data;
        qhe_pkg::REG_END_ACC:   a2_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  qhe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser),
    .in_time    (in_tdata),
    .t_start    (t_start_r),
    .t_end      (t_end_r),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  qhe_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (item_valid),
    .push_ready (item_ready),
    .push_item  (item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  qhe_back #(
    .AXES       (AXES),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .p1         (p1_r),
    .p2         (p2_r),
    .v1         (v1_r),
    .v2         (v2_r),
    .a1         (a1_r),
    .a2         (a2_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_x      (res_x),
    .out_y      (res_y),
    .out_z      (res_z),
    .out_flag   (res_flag)
  );

  assign out_tdata = {7'b0, res_flag, res_z, res_y, res_x};

endmodule

>>> src/qhe_front.sv
// Front end: clamps the sample time and normalises it to unsigned Q1.16 (0 to 1.0) with a
// restoring divider pipeline, one quotient bit per stage. Uses qhe_pkg.
module qhe_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic [qhe_pkg::TIME_W-1:0]   in_time,
  input  logic [qhe_pkg::TIME_W-1:0]   t_start,
  input  logic [qhe_pkg::TIME_W-1:0]   t_end,
  output logic                         item_valid,
  input  logic                         item_ready,
  output qhe_pkg::item_t               item
);

  localparam int UW = qhe_pkg::U_W;
  localparam int TW = qhe_pkg::TIME_W;
  localparam int NS = UW + 1;  // classify stage plus one stage per quotient bit

  logic          v_r    [NS];
  logic [1:0]    mode_r [NS];
  logic          flag_r [NS];
  logic [TW-1:0] den_r  [NS];
  logic [UW-1:0] rem_r  [NS];
  logic [UW-1:0] q_r    [NS];

  logic [UW-1:0] rin      [NS];
  logic          ge       [NS];
  logic [UW-1:0] rem_nxt  [NS];
  logic [UW-1:0] q_nxt    [NS];

  logic          en;
  logic          c_flag;
  logic [TW-1:0] c_diff;
  logic [TW-1:0] c_den;
  logic [TW-1:0] tc;

  assign en       = !(v_r[NS-1] && !item_ready);
  assign in_ready = en;

  always_comb begin
    tc = in_time;
    if (t_end <= t_start) begin
      // empty or reversed segment: u stays zero
      c_flag = (in_time != t_start);
      c_diff = '0;
      c_den  = TW'(1);
    end else begin
      c_flag = (in_time < t_start) || (in_time > t_end);
      if (in_time < t_start) begin
        tc = t_start;
      end else if (in_time > t_end) begin
        tc = t_end;
      end
      c_diff = tc - t_start;
      c_den  = t_end - t_start;
    end
  end

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      rin[j]     = '0;
      ge[j]      = 1'b0;
      rem_nxt[j] = '0;
      q_nxt[j]   = '0;
    end
    for (int j = 1; j < NS; j++) begin
      rin[j]     = (j == 1) ? rem_r[0] : {rem_r[j-1][UW-2:0], 1'b0};
      ge[j]      = rin[j] >= {1'b0, den_r[j-1]};
      rem_nxt[j] = ge[j] ? (rin[j] - {1'b0, den_r[j-1]}) : rin[j];
      q_nxt[j]   = q_r[j-1];
      q_nxt[j][NS-1-j] = ge[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int j = 1; j < NS; j++) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r[0] <= in_mode;
      flag_r[0] <= c_flag;
      den_r[0]  <= c_den;
      rem_r[0]  <= {1'b0, c_diff};
      q_r[0]    <= '0;
      for (int j = 1; j < NS; j++) begin
        mode_r[j] <= mode_r[j-1];
        flag_r[j] <= flag_r[j-1];
        den_r[j]  <= den_r[j-1];
        rem_r[j]  <= rem_nxt[j];
        q_r[j]    <= q_nxt[j];
      end
    end
  end

  assign item_valid = v_r[NS-1];
  assign item.mode  = mode_r[NS-1];
  assign item.flag  = flag_r[NS-1];
  assign item.u     = q_r[NS-1];

endmodule

>>> src/qhe_fifo.sv
// Short queue between the front and back ends so each side stalls on its own.
// Uses qhe_pkg for the item type and depth.
module qhe_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  qhe_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output qhe_pkg::item_t pop_item
);

  localparam int DEPTH = qhe_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  qhe_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wr_r, wr_nxt;
  logic [AW-1:0]  rd_r, rd_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != (AW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + AW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + AW'(1) : rd_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

>>> src/qhe_back.sv
// Back end: Horner evaluation of the six basis lanes, weighting of the endpoint
// data, rounding and saturation into the output register. Uses qhe_pkg.
module qhe_back #(
  parameter int AXES       = qhe_pkg::AXES_DEF,
  parameter int COORD_BITS = qhe_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  qhe_pkg::item_t              item,
  input  logic [qhe_pkg::CFG_W-1:0]   p1,
  input  logic [qhe_pkg::CFG_W-1:0]   p2,
  input  logic [qhe_pkg::CFG_W-1:0]   v1,
  input  logic [qhe_pkg::CFG_W-1:0]   v2,
  input  logic [qhe_pkg::CFG_W-1:0]   a1,
  input  logic [qhe_pkg::CFG_W-1:0]   a2,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [qhe_pkg::RES_W-1:0]   out_x,
  output logic [qhe_pkg::RES_W-1:0]   out_y,
  output logic [qhe_pkg::RES_W-1:0]   out_z,
  output logic                        out_flag
);

  localparam int UW    = qhe_pkg::U_W;
  localparam int XW    = UW + 1;
  localparam int WW    = qhe_pkg::WGT_W;
  localparam int MULW  = WW + XW;
  localparam int CW    = COORD_BITS + 1;
  localparam int PRW   = WW + CW;
  localparam int SUMW  = (PRW + 3 > 49) ? PRW + 3 : 49;
  localparam int PADW  = qhe_pkg::NAX * COORD_BITS + qhe_pkg::CFG_W;
  localparam int NL    = qhe_pkg::NLANE;
  localparam int NT    = qhe_pkg::NTERM;
  localparam int NH    = qhe_pkg::HORNER;
  localparam int NAX   = qhe_pkg::NAX;
  localparam int RW    = qhe_pkg::RES_W;
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(2147483647);
  localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

  // Horner stages: 0 loads the leading coefficient, 1..NH fold one power each
  logic                    hv_r   [NH+1];
  logic [1:0]              hmode_r[NH+1];
  logic                    hflag_r[NH+1];
  logic [UW-1:0]           u_r    [NH+1];
  logic [UW-1:0]           uc_r   [NH+1];
  logic signed [WW-1:0]    b_r    [NH+1][NL];

  logic signed [XW-1:0]    xs     [NH+1][NL];
  logic signed [MULW-1:0]  mul    [NH+1][NL];
  logic signed [WW-1:0]    b_nxt  [NH+1][NL];

  logic                    pv_r, pflag_r;
  logic [1:0]              pmode_r;
  logic signed [PRW-1:0]   prod_r [NAX][NT];
  logic signed [PRW-1:0]   prod_nxt[NAX][NT];

  logic                    ov_r, oflag_r;
  logic [RW-1:0]           res_r  [NAX];
  logic [RW-1:0]           res_nxt[NAX];

  logic [PADW-1:0]         pp1, pp2, pv1, pv2, pa1, pa2;
  logic signed [CW-1:0]    c_p1[NAX], c_p2[NAX], c_v1[NAX], c_v2[NAX];
  logic signed [CW-1:0]    c_a1[NAX], c_a2[NAX];
  logic signed [SUMW-1:0]  sum[NAX], rnd[NAX], sh[NAX];
  logic [UW-1:0]           uc0;
  logic                    neg_end;
  logic                    en;

  assign en         = !ov_r || out_ready;
  assign item_ready = en;
  assign uc0        = UW'(qhe_pkg::QONE) - item.u;

  always_comb begin
    for (int s = 0; s <= NH; s++) begin
      for (int l = 0; l < NL; l++) begin
        xs[s][l]    = '0;
        mul[s][l]   = '0;
        b_nxt[s][l] = '0;
      end
    end
    for (int s = 1; s <= NH; s++) begin
      for (int l = 0; l < NL; l++) begin
        xs[s][l]    = (l < 3) ? signed'({1'b0, u_r[s-1]}) : signed'({1'b0, uc_r[s-1]});
        mul[s][l]   = b_r[s-1][l] * xs[s][l];
        b_nxt[s][l] = WW'(mul[s][l] >>> 16) + qhe_pkg::coef(hmode_r[s-1], l % 3, NH - s);
      end
    end
  end

  // endpoint coordinates, sign-extended one bit so negation cannot overflow
  always_comb begin
    pp1 = PADW'(p1);
    pp2 = PADW'(p2);
    pv1 = PADW'(v1);
    pv2 = PADW'(v2);
    pa1 = PADW'(a1);
    pa2 = PADW'(a2);
    neg_end = (hmode_r[NH] == qhe_pkg::MODE_VEL);
    for (int a = 0; a < NAX; a++) begin
      c_p1[a] = signed'({pp1[a*COORD_BITS + COORD_BITS - 1], pp1[a*COORD_BITS +: COORD_BITS]});
      c_p2[a] = signed'({pp2[a*COORD_BITS + COORD_BITS - 1], pp2[a*COORD_BITS +: COORD_BITS]});
      c_v1[a] = signed'({pv1[a*COORD_BITS + COORD_BITS - 1], pv1[a*COORD_BITS +: COORD_BITS]});
      c_v2[a] = signed'({pv2[a*COORD_BITS + COORD_BITS - 1], pv2[a*COORD_BITS +: COORD_BITS]});
      c_a1[a] = signed'({pa1[a*COORD_BITS + COORD_BITS - 1], pa1[a*COORD_BITS +: COORD_BITS]});
      c_a2[a] = signed'({pa2[a*COORD_BITS + COORD_BITS - 1], pa2[a*COORD_BITS +: COORD_BITS]});
      prod_nxt[a][0] = b_r[NH][0] * c_p1[a];
      prod_nxt[a][1] = b_r[NH][1] * c_v1[a];
      prod_nxt[a][2] = b_r[NH][2] * c_a1[a];
      prod_nxt[a][3] = b_r[NH][5] * (neg_end ? -c_a2[a] : c_a2[a]);
      prod_nxt[a][4] = b_r[NH][4] * (neg_end ? c_v2[a] : -c_v2[a]);
      prod_nxt[a][5] = b_r[NH][3] * (neg_end ? -c_p2[a] : c_p2[a]);
    end
  end

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      sum[a] = SUMW'(prod_r[a][0]) + SUMW'(prod_r[a][1]) + SUMW'(prod_r[a][2])
             + SUMW'(prod_r[a][3]) + SUMW'(prod_r[a][4]) + SUMW'(prod_r[a][5]);
      rnd[a] = sum[a] + SUMW'(32768);
      sh[a]  = rnd[a] >>> 16;
      if ((pmode_r > qhe_pkg::MODE_ACC) || (a >= AXES)) begin
        res_nxt[a] = '0;
      end else if (sh[a] > SAT_HI) begin
        res_nxt[a] = RW'(SAT_HI);
      end else if (sh[a] < SAT_LO) begin
        res_nxt[a] = RW'(SAT_LO);
      end else begin
        res_nxt[a] = RW'(sh[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NH; s++) begin
        hv_r[s] <= 1'b0;
      end
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      hv_r[0] <= item_valid;
      for (int s = 1; s <= NH; s++) begin
        hv_r[s] <= hv_r[s-1];
      end
      pv_r <= hv_r[NH];
      ov_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hmode_r[0] <= item.mode;
      hflag_r[0] <= item.flag;
      u_r[0]     <= item.u;
      uc_r[0]    <= uc0;
      for (int l = 0; l < NL; l++) begin
        b_r[0][l] <= qhe_pkg::coef(item.mode, l % 3, NH);
      end
      for (int s = 1; s <= NH; s++) begin
        hmode_r[s] <= hmode_r[s-1];
        hflag_r[s] <= hflag_r[s-1];
        u_r[s]     <= u_r[s-1];
        uc_r[s]    <= uc_r[s-1];
        for (int l = 0; l < NL; l++) begin
          b_r[s][l] <= b_nxt[s][l];
        end
      end
      pmode_r <= hmode_r[NH];
      pflag_r <= hflag_r[NH];
      for (int a = 0; a < NAX; a++) begin
        for (int t = 0; t < NT; t++) begin
          prod_r[a][t] <= prod_nxt[a][t];
        end
        res_r[a] <= res_nxt[a];
      end
      oflag_r <= pflag_r;
    end
  end

  assign out_valid = ov_r;
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];
  assign out_flag  = oflag_r;

endmodule

>>> sim/tb.sv
// Self-checking bench for quintic_hermite_eval: segment setup, sample-time sweeps, all modes.
// Needs qhe_pkg and the evaluator; expected results are computed in the trajectory class.
`timescale 1ns / 1ps

class traj_scoreboard;
  logic [15:0] seg_start, seg_end;
  logic [47:0] seg_reg [2:7];
  logic [103:0] pending [$];
  int errors;

  function new();
    seg_start = 16'd0;
    seg_end = 16'hFFFF;
    for (int i = 2; i < 8; i++) seg_reg[i] = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [47:0] val);
    if (idx == qhe_pkg::REG_T_START) seg_start = val[15:0];
    else if (idx == qhe_pkg::REG_T_END) seg_end = val[15:0];
    else seg_reg[idx] = val;
  endfunction

  function longint fshift(longint x);
    return x >>> 16;
  endfunction

  function longint horner(logic [1:0] m, int b, longint u);
    longint acc;
    acc = qhe_pkg::COEF_TAB[m][b][5];
    for (int k = 4; k >= 0; k--) acc = fshift(acc * u) + qhe_pkg::COEF_TAB[m][b][k];
    return acc;
  endfunction

  function longint axis_coord(logic [2:0] idx, int ax);
    logic signed [15:0] c;
    c = seg_reg[idx][ax*16 +: 16];
    return longint'(c);
  endfunction

  function void note_sample(logic [1:0] mode, logic [15:0] ts);
    logic flag;
    longint u, acc, r, sgn;
    longint w [3];
    longint wr [3];
    logic [103:0] res;
    logic [15:0] tc;
    if (seg_end <= seg_start) begin
      flag = (ts != seg_start);
      u = 0;
    end else begin
      flag = (ts < seg_start) || (ts > seg_end);
      tc = ts < seg_start ? seg_start : (ts > seg_end ? seg_end : ts);
      u = ((longint'(tc) - seg_start) <<< 16) / (longint'(seg_end) - seg_start);
    end
    res = '0;
    res[96] = flag;
    if (mode <= qhe_pkg::MODE_ACC) begin
      for (int b = 0; b < 3; b++) begin
        w[b] = horner(mode, b, u);
        wr[b] = horner(mode, b, 65536 - u);
      end
      sgn = (mode == qhe_pkg::MODE_VEL) ? -1 : 1;
      for (int ax = 0; ax < 3; ax++) begin
        acc = w[0] * axis_coord(qhe_pkg::REG_START_POS, ax)
            + w[1] * axis_coord(qhe_pkg::REG_START_VEL, ax)
            + w[2] * axis_coord(qhe_pkg::REG_START_ACC, ax)
            + sgn * wr[2] * axis_coord(qhe_pkg::REG_END_ACC, ax)
            - sgn * wr[1] * axis_coord(qhe_pkg::REG_END_VEL, ax)
            + sgn * wr[0] * axis_coord(qhe_pkg::REG_END_POS, ax);
        r = fshift(acc + 32768);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        res[ax*32 +: 32] = r[31:0];
      end
    end
    pending.push_back(res);
  endfunction

  function void check_result(logic [103:0] got);
    logic [103:0] exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    for (int ax = 0; ax < 3; ax++)
      if (got[ax*32 +: 32] !== exp_r[ax*32 +: 32]) begin
        $display("%0t: axis %0d expected %0d got %0d", $time, ax,
                 $signed(exp_r[ax*32 +: 32]), $signed(got[ax*32 +: 32]));
        errors++;
      end
    if (got[96] !== exp_r[96]) begin
      $display("%0t: range flag expected %b got %b", $time, exp_r[96], got[96]);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [15:0] in_tdata;
  logic [1:0] in_tuser;
  logic [103:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;
  traj_scoreboard sb;
  bit calm;
  int idle_cycles;

  quintic_hermite_eval dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure bursts
  initial begin
    int stall;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13);
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (rst_n && ((out_tvalid && out_tready) || (in_tvalid && in_tready) ||
                  (cfg_valid && cfg_ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  // cfg_valid is lowered after each write before the next one, so each write is one update
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_sample(logic [1:0] mode, logic [15:0] ts);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= ts;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(mode, ts);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [47:0] rnd48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic random_setup(int kind);
    logic [15:0] a, b;
    a = 16'($urandom());
    b = 16'($urandom());
    if (kind == 0) begin
      a = 16'd0;
      b = 16'hFFFF;
    end else if (kind == 1) begin
      b = a;
    end else if (kind == 2 && a < b) begin
      {a, b} = {b, a};
    end else if (a > b) begin
      {a, b} = {b, a};
    end
    write_reg(qhe_pkg::REG_T_START, {32'h0, a});
    write_reg(qhe_pkg::REG_T_END, {32'h0, b});
    for (int i = 2; i < 8; i++)
      write_reg(3'(i), (kind == 3) ? 48'h7FFF_7FFF_7FFF :
                       (kind == 4) ? 48'h8000_8000_8000 : rnd48());
  endtask

  initial begin
    logic [15:0] ts;
    sb = new();
    calm = 0;
    idle_cycles = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset segment with zero data, then directed extremes
    send_sample(qhe_pkg::MODE_POS, 16'h0000);
    drain();
    write_reg(qhe_pkg::REG_T_START, 48'd1000);
    write_reg(qhe_pkg::REG_T_END, 48'd3000);
    for (int i = 2; i < 8; i++) write_reg(3'(i), rnd48());
    for (int m = 0; m < 4; m++) begin
      send_sample(2'(m), 16'd0);
      send_sample(2'(m), 16'd1000);
      send_sample(2'(m), 16'd2000);
      send_sample(2'(m), 16'd3000);
      send_sample(2'(m), 16'hFFFF);
    end
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      random_setup(phase % 6);
      if (phase == 10) calm = 1;
      for (int n = 0; n < 120; n++) begin
        case ($urandom_range(0, 9))
          0: ts = sb.seg_start;
          1: ts = sb.seg_end;
          2, 3: ts = 16'($urandom());
          default: ts = (sb.seg_end > sb.seg_start) ?
                        16'($urandom_range(sb.seg_start, sb.seg_end)) : 16'($urandom());
        endcase
        send_sample(($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2)), ts);
      end
      drain();
    end

    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
